// File: hw/rtl/src_pkg.sv
// Shared constants and types of the segment rectangle clipper.
`default_nettype none
package src_pkg;

   localparam int CSR_INDEX_BITS = 3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_RECT_X_MIN = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RECT_Y_MIN = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RECT_X_MAX = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RECT_Y_MAX = 3'd3;

   localparam int RECT_MIN_RESET = 0;
   localparam int RECT_MAX_RESET = 65536;

   typedef enum logic [1:0] {
      EDGE_LEFT   = 2'd0,
      EDGE_TOP    = 2'd1,
      EDGE_RIGHT  = 2'd2,
      EDGE_BOTTOM = 2'd3
   } edge_sel_type;

   typedef struct packed {
      logic x_min;
      logic y_min;
      logic x_max;
      logic y_max;
   } csr_hit_type;

endpackage
`default_nettype wire

// File: hw/rtl/segment_rect_clipper.sv
// Top level of the segment rectangle clipper: rectangle registers and stage wiring.
//
//   channel  direction  handshake               payload
//   req      in         req_valid/req_ready     start_x start_y end_x end_y
//   rsp      out        rsp_valid/rsp_ready     kept clipped_start/end_x/y
//   csr      in         csr_valid/csr_ready     csr_index csr_data
//
// A segment wholly inside the rectangle skips the edge tests: the back stage takes it, then
// loads the result. Otherwise the back stage takes the segment, tests edge by edge, runs a
// serial multiply-divide (one step per cycle) and then the update for an edge that moves an
// end, and at last loads the result. The front takes a new segment every cycle until the
// two-entry queue and its own register are full. Synchronous reset clears control and
// loads the rectangle reset values; csr_ready is always high.
`default_nettype none
module segment_rect_clipper import src_pkg::*; #(
   parameter int COORD_BITS = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic signed [COORD_BITS-1:0] req_start_x,
   input  wire logic signed [COORD_BITS-1:0] req_start_y,
   input  wire logic signed [COORD_BITS-1:0] req_end_x,
   input  wire logic signed [COORD_BITS-1:0] req_end_y,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic                              rsp_kept,
   output logic signed [COORD_BITS-1:0]      rsp_clipped_start_x,
   output logic signed [COORD_BITS-1:0]      rsp_clipped_start_y,
   output logic signed [COORD_BITS-1:0]      rsp_clipped_end_x,
   output logic signed [COORD_BITS-1:0]      rsp_clipped_end_y,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [COORD_BITS-1:0]        csr_data
);

   localparam int QW = 4 * COORD_BITS + 1;

   logic signed [COORD_BITS-1:0] x_min_ff, y_min_ff, x_max_ff, y_max_ff;
   csr_hit_type                  hit;
   logic                         f_valid, f_ready, b_valid, b_ready;
   logic [QW-1:0]                f_data, b_data;

   assign csr_ready = 1'b1;

   always_comb begin
      hit.x_min = csr_valid && (csr_index == CSR_RECT_X_MIN);
      hit.y_min = csr_valid && (csr_index == CSR_RECT_Y_MIN);
      hit.x_max = csr_valid && (csr_index == CSR_RECT_X_MAX);
      hit.y_max = csr_valid && (csr_index == CSR_RECT_Y_MAX);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_min_ff <= COORD_BITS'(RECT_MIN_RESET);
         y_min_ff <= COORD_BITS'(RECT_MIN_RESET);
         x_max_ff <= COORD_BITS'(RECT_MAX_RESET);
         y_max_ff <= COORD_BITS'(RECT_MAX_RESET);
      end else begin
         if (hit.x_min) x_min_ff <= csr_data;
         if (hit.y_min) y_min_ff <= csr_data;
         if (hit.x_max) x_max_ff <= csr_data;
         if (hit.y_max) y_max_ff <= csr_data;
      end
   end

   src_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_start_x(req_start_x), .req_start_y(req_start_y),
      .req_end_x(req_end_x), .req_end_y(req_end_y),
      .rect_x_min(x_min_ff), .rect_y_min(y_min_ff),
      .rect_x_max(x_max_ff), .rect_y_max(y_max_ff),
      .push_valid(f_valid), .push_ready(f_ready), .push_data(f_data)
   );

   src_fifo #(.WIDTH(QW)) u_fifo (
      .clock(clock), .reset(reset),
      .push_valid(f_valid), .push_ready(f_ready), .push_data(f_data),
      .pop_valid(b_valid), .pop_ready(b_ready), .pop_data(b_data)
   );

   src_back #(.COORD_BITS(COORD_BITS)) u_back (
      .clock(clock), .reset(reset),
      .pop_valid(b_valid), .pop_ready(b_ready), .pop_data(b_data),
      .rect_x_min(x_min_ff), .rect_y_min(y_min_ff),
      .rect_x_max(x_max_ff), .rect_y_max(y_max_ff),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_kept(rsp_kept),
      .rsp_clipped_start_x(rsp_clipped_start_x),
      .rsp_clipped_start_y(rsp_clipped_start_y),
      .rsp_clipped_end_x(rsp_clipped_end_x),
      .rsp_clipped_end_y(rsp_clipped_end_y)
   );

endmodule
`default_nettype wire

// File: hw/rtl/src_front.sv
// Front stage: accepts a segment and flags one that lies wholly inside the rectangle.
`default_nettype none
module src_front import src_pkg::*; #(
   parameter int COORD_BITS = 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic signed [COORD_BITS-1:0] req_start_x,
   input  wire logic signed [COORD_BITS-1:0] req_start_y,
   input  wire logic signed [COORD_BITS-1:0] req_end_x,
   input  wire logic signed [COORD_BITS-1:0] req_end_y,
   input  wire logic signed [COORD_BITS-1:0] rect_x_min,
   input  wire logic signed [COORD_BITS-1:0] rect_y_min,
   input  wire logic signed [COORD_BITS-1:0] rect_x_max,
   input  wire logic signed [COORD_BITS-1:0] rect_y_max,
   output logic                            push_valid,
   input  wire logic                       push_ready,
   output logic [4*COORD_BITS:0]           push_data
);

   logic                  valid_ff, valid_in;
   logic [4*COORD_BITS:0] data_ff;
   logic                  all_in;

   always_comb begin
      all_in = (req_start_x >= rect_x_min) && (req_start_x <= rect_x_max) &&
               (req_end_x   >= rect_x_min) && (req_end_x   <= rect_x_max) &&
               (req_start_y >= rect_y_min) && (req_start_y <= rect_y_max) &&
               (req_end_y   >= rect_y_min) && (req_end_y   <= rect_y_max);
   end

   assign req_ready  = !valid_ff || push_ready;
   assign push_valid = valid_ff;
   assign push_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (push_ready) begin
         valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_valid && req_ready) begin
         data_ff <= {all_in, req_start_x, req_start_y, req_end_x, req_end_y};
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/src_fifo.sv
// Two-entry queue between the front and back stages.
`default_nettype none
module src_fifo import src_pkg::*; #(
   parameter int WIDTH = 129
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output logic [WIDTH-1:0]      pop_data
);

   logic [WIDTH-1:0] mem [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = mem[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      count_in = count_ff;
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/src_back.sv
// Back stage: clips edge by edge with a serial multiply-divide and holds the result.
`default_nettype none
module src_back import src_pkg::*; #(
   parameter int COORD_BITS = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         pop_valid,
   output logic                              pop_ready,
   input  wire logic [4*COORD_BITS:0]        pop_data,
   input  wire logic signed [COORD_BITS-1:0] rect_x_min,
   input  wire logic signed [COORD_BITS-1:0] rect_y_min,
   input  wire logic signed [COORD_BITS-1:0] rect_x_max,
   input  wire logic signed [COORD_BITS-1:0] rect_y_max,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic                              rsp_kept,
   output logic signed [COORD_BITS-1:0]      rsp_clipped_start_x,
   output logic signed [COORD_BITS-1:0]      rsp_clipped_start_y,
   output logic signed [COORD_BITS-1:0]      rsp_clipped_end_x,
   output logic signed [COORD_BITS-1:0]      rsp_clipped_end_y
);

   localparam int W  = COORD_BITS;
   localparam int CW = $clog2(W + 2);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_EVAL = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_FIN  = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type           state_ff;
   edge_sel_type        edge_ff;
   logic                kept_ff;
   logic signed [W-1:0] p0x_ff, p0y_ff, p1x_ff, p1y_ff;
   logic                outside_ff, neg_ff;
   logic signed [W-1:0] base_ff;
   logic [W:0]          a_ff, b_ff, d_ff, rem_ff;
   logic [W+2:0]        q_ff;
   logic [CW-1:0]       cnt_ff;

   logic                rsp_valid_ff, rsp_valid_in, rsp_kept_ff;
   logic signed [W-1:0] rsp_sx_ff, rsp_sy_ff, rsp_ex_ff, rsp_ey_ff;

   logic                ax;
   logic signed [W-1:0] bound, c0, c1, o0, o1;
   logic signed [W:0]   r0, r1, rin, rout, delta;
   logic [W:0]          mag, neg_rin;
   logic [W+1:0]        span;
   logic [W+2:0]        t0, t1, t2;
   logic [1:0]          digit;
   logic [W:0]          rem_next;
   logic [W+2:0]        off;
   logic signed [W+3:0] moved;
   logic                out_free;
   logic                last_edge;

   assign ax        = edge_ff[0];
   assign last_edge = (edge_ff == EDGE_BOTTOM);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pop_ready = (state_ff == ST_IDLE);

   always_comb begin
      unique case (edge_ff)
         EDGE_LEFT:   bound = rect_x_min;
         EDGE_TOP:    bound = rect_y_max;
         EDGE_RIGHT:  bound = rect_x_max;
         EDGE_BOTTOM: bound = rect_y_min;
         default:     bound = rect_x_min;
      endcase
      c0 = ax ? p0y_ff : p0x_ff;
      c1 = ax ? p1y_ff : p1x_ff;
      o0 = ax ? p0x_ff : p0y_ff;
      o1 = ax ? p1x_ff : p1y_ff;
      if (edge_ff == EDGE_TOP || edge_ff == EDGE_RIGHT) begin
         r0 = (W+1)'(c0) - (W+1)'(bound);
         r1 = (W+1)'(c1) - (W+1)'(bound);
      end else begin
         r0 = (W+1)'(bound) - (W+1)'(c0);
         r1 = (W+1)'(bound) - (W+1)'(c1);
      end
      rin     = (r0 < 0) ? r0 : r1;
      rout    = (r0 < 0) ? r1 : r0;
      delta   = (r0 < 0) ? ((W+1)'(o1) - (W+1)'(o0)) : ((W+1)'(o0) - (W+1)'(o1));
      mag     = delta[W] ? (W+1)'(-delta) : (W+1)'(delta);
      neg_rin = (W+1)'(-rin);
      span    = (W+2)'(rout) - (W+2)'(rin);
   end

   always_comb begin
      t0 = {1'b0, rem_ff, 1'b0} + (a_ff[W] ? (W+3)'(b_ff) : '0);
      t1 = t0 - (W+3)'(d_ff);
      t2 = t0 - {1'b0, d_ff, 1'b0};
      if (t0 >= {1'b0, d_ff, 1'b0}) begin
         digit    = 2'd2;
         rem_next = t2[W:0];
      end else if (t0 >= (W+3)'(d_ff)) begin
         digit    = 2'd1;
         rem_next = t1[W:0];
      end else begin
         digit    = 2'd0;
         rem_next = t0[W:0];
      end
      off   = q_ff + (({1'b0, rem_ff, 1'b0} >= (W+3)'(d_ff)) ? (W+3)'(1) : '0);
      moved = neg_ff ? ((W+4)'(base_ff) - (W+4)'(off)) : ((W+4)'(base_ff) + (W+4)'(off));
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == ST_DONE && out_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         unique case (state_ff)
            ST_IDLE: begin
               if (pop_valid) begin
                  {p0x_ff, p0y_ff, p1x_ff, p1y_ff} <= pop_data[4*W-1:0];
                  kept_ff  <= 1'b1;
                  edge_ff  <= EDGE_LEFT;
                  state_ff <= pop_data[4*W] ? ST_DONE : ST_EVAL;
               end
            end
            ST_EVAL: begin
               if (r0 <= 0 && r1 <= 0) begin
                  if (last_edge) begin
                     state_ff <= ST_DONE;
                  end else begin
                     edge_ff <= edge_sel_type'(edge_ff + 2'd1);
                  end
               end else if ((r0 < 0 && r1 > 0) || (r0 > 0 && r1 < 0)) begin
                  outside_ff <= (r0 < 0);
                  base_ff    <= (r0 < 0) ? o0 : o1;
                  neg_ff     <= delta[W];
                  a_ff       <= mag;
                  b_ff       <= neg_rin;
                  d_ff       <= span[W:0];
                  rem_ff     <= '0;
                  q_ff       <= '0;
                  cnt_ff     <= CW'(W + 1);
                  if (r0 < 0) begin
                     if (ax) p1y_ff <= bound; else p1x_ff <= bound;
                  end else begin
                     if (ax) p0y_ff <= bound; else p0x_ff <= bound;
                  end
                  state_ff <= ST_DIV;
               end else begin
                  kept_ff  <= 1'b0;
                  state_ff <= ST_DONE;
               end
            end
            ST_DIV: begin
               a_ff   <= {a_ff[W-1:0], 1'b0};
               rem_ff <= rem_next;
               q_ff   <= {q_ff[W+1:0], 1'b0} + (W+3)'(digit);
               cnt_ff <= cnt_ff - CW'(1);
               if (cnt_ff == CW'(1)) begin
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               if (outside_ff) begin
                  if (ax) p1x_ff <= moved[W-1:0]; else p1y_ff <= moved[W-1:0];
               end else begin
                  if (ax) p0x_ff <= moved[W-1:0]; else p0y_ff <= moved[W-1:0];
               end
               if (last_edge) begin
                  state_ff <= ST_DONE;
               end else begin
                  edge_ff  <= edge_sel_type'(edge_ff + 2'd1);
                  state_ff <= ST_EVAL;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_kept_ff  <= kept_ff;
                  rsp_sx_ff    <= kept_ff ? p0x_ff : '0;
                  rsp_sy_ff    <= kept_ff ? p0y_ff : '0;
                  rsp_ex_ff    <= kept_ff ? p1x_ff : '0;
                  rsp_ey_ff    <= kept_ff ? p1y_ff : '0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_kept            = rsp_kept_ff;
   assign rsp_clipped_start_x = rsp_sx_ff;
   assign rsp_clipped_start_y = rsp_sy_ff;
   assign rsp_clipped_end_x   = rsp_ex_ff;
   assign rsp_clipped_end_y   = rsp_ey_ff;

endmodule
`default_nettype wire

// File: verif/segment_rect_clipper_tb.sv
// Testbench for segment_rect_clipper: random and directed segments against a predictor.
module segment_rect_clipper_tb import src_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CB = 32;
   localparam int STALL_LIMIT = 6000;
   localparam int HOLD_CYCLES = 400;

   typedef logic signed [CB-1:0] coord_type;

   typedef struct {
      coord_type sx, sy, ex, ey;
   } segment_type;

   typedef struct {
      logic      kept;
      coord_type sx, sy, ex, ey;
   } clip_type;

   class clip_scoreboard_type;
      clip_type  expected_q[$];
      coord_type x_min, y_min, x_max, y_max;
      int        errors;
      int        checked;
      int        deleted;

      function new();
         x_min = coord_type'(RECT_MIN_RESET);
         y_min = coord_type'(RECT_MIN_RESET);
         x_max = coord_type'(RECT_MAX_RESET);
         y_max = coord_type'(RECT_MAX_RESET);
      endfunction

      task report(string msg);
         $display("MISMATCH @%0t: %s", $realtime, msg);
         errors++;
      endtask

      function void write_reg(logic [CSR_INDEX_BITS-1:0] idx, coord_type val);
         case (idx)
            CSR_RECT_X_MIN: x_min = val;
            CSR_RECT_Y_MIN: y_min = val;
            CSR_RECT_X_MAX: x_max = val;
            CSR_RECT_Y_MAX: y_max = val;
            default: ;
         endcase
      endfunction

      function clip_type clip_segment(segment_type s);
         longint p[2][2];
         longint bnd[4];
         longint d0, d1, rin, rout, base, delta, mag;
         logic [127:0] prod, dv, q, rem;
         int ax, ins, outs;
         bit pos;
         edge_sel_type e;
         clip_type r;
         r.kept = 1'b1;
         p[0][0] = s.sx; p[0][1] = s.sy; p[1][0] = s.ex; p[1][1] = s.ey;
         bnd[EDGE_LEFT] = x_min;
         bnd[EDGE_TOP] = y_max;
         bnd[EDGE_RIGHT] = x_max;
         bnd[EDGE_BOTTOM] = y_min;
         for (int i = 0; i < 4 && r.kept; i++) begin
            e = edge_sel_type'(i);
            ax = (e == EDGE_LEFT || e == EDGE_RIGHT) ? 0 : 1;
            pos = (e == EDGE_TOP || e == EDGE_RIGHT);
            d0 = pos ? p[0][ax] - bnd[i] : bnd[i] - p[0][ax];
            d1 = pos ? p[1][ax] - bnd[i] : bnd[i] - p[1][ax];
            if (d0 <= 0 && d1 <= 0) continue;
            if (d0 < 0 && d1 > 0) begin
               ins = 0; outs = 1;
            end else if (d0 > 0 && d1 < 0) begin
               ins = 1; outs = 0;
            end else begin
               r.kept = 1'b0;
               break;
            end
            rin = ins ? d1 : d0;
            rout = ins ? d0 : d1;
            base = p[ins][1-ax];
            delta = p[outs][1-ax] - base;
            mag = delta < 0 ? -delta : delta;
            prod = 128'(mag) * 128'(-rin);
            dv = 128'(rout - rin);
            q = prod / dv;
            rem = prod % dv;
            if (rem >= dv - rem) q++;
            p[outs][1-ax] = delta < 0 ? base - longint'(q) : base + longint'(q);
            p[outs][ax] = bnd[i];
         end
         r.sx = r.kept ? coord_type'(p[0][0]) : '0;
         r.sy = r.kept ? coord_type'(p[0][1]) : '0;
         r.ex = r.kept ? coord_type'(p[1][0]) : '0;
         r.ey = r.kept ? coord_type'(p[1][1]) : '0;
         return r;
      endfunction

      function void note_segment(segment_type s);
         expected_q.push_back(clip_segment(s));
      endfunction

      task check_result(clip_type got);
         clip_type x;
         if (expected_q.size() == 0) begin
            report("result with no segment pending");
            return;
         end
         x = expected_q.pop_front();
         checked++;
         if (!x.kept) deleted++;
         if (got.kept !== x.kept) report($sformatf("kept %0b exp %0b", got.kept, x.kept));
         if (got.sx !== x.sx) report($sformatf("start_x %0d exp %0d", got.sx, x.sx));
         if (got.sy !== x.sy) report($sformatf("start_y %0d exp %0d", got.sy, x.sy));
         if (got.ex !== x.ex) report($sformatf("end_x %0d exp %0d", got.ex, x.ex));
         if (got.ey !== x.ey) report($sformatf("end_y %0d exp %0d", got.ey, x.ey));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   coord_type req_start_x = '0, req_start_y = '0, req_end_x = '0, req_end_y = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_kept;
   coord_type rsp_clipped_start_x, rsp_clipped_start_y, rsp_clipped_end_x, rsp_clipped_end_y;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CB-1:0] csr_data = '0;

   clip_scoreboard_type sb = new();
   bit quiet = 0;
   bit hold_request = 0;
   int stall_count = 0;
   int sent = 0;

   segment_rect_clipper #(.COORD_BITS(CB)) dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_segment('{req_start_x, req_start_y, req_end_x, req_end_y});
         if (rsp_valid && rsp_ready)
            sb.check_result('{rsp_kept, rsp_clipped_start_x, rsp_clipped_start_y,
                              rsp_clipped_end_x, rsp_clipped_end_y});
         if (csr_valid && csr_ready)
            sb.write_reg(csr_index, csr_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            stall_count = 0;
         else
            stall_count++;
         if (stall_count >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_ready = 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_request = 0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(0, 10)) @(negedge clock);
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   task automatic send_segment(segment_type s);
      if (!quiet && $urandom_range(0, 9) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_start_x = s.sx; req_start_y = s.sy; req_end_x = s.ex; req_end_y = s.ey;
      do @(posedge clock); while (!(req_valid && req_ready));
      sent++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic write_csr(logic [CSR_INDEX_BITS-1:0] idx, coord_type val);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = val;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic drain();
      wait (sb.expected_q.size() == 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_rect(coord_type x0, coord_type y0, coord_type x1, coord_type y1);
      drain();
      write_csr(CSR_RECT_X_MIN, x0);
      write_csr(CSR_RECT_Y_MIN, y0);
      write_csr(CSR_RECT_X_MAX, x1);
      write_csr(CSR_RECT_Y_MAX, y1);
   endtask

   function automatic coord_type pick(coord_type lo, coord_type hi);
      longint a, b, span;
      a = (lo < hi) ? lo : hi;
      b = (lo < hi) ? hi : lo;
      span = b - a + 16;
      if (span > 64'sd1 << 31) span = 64'sd1 << 31;
      case ($urandom_range(0, 9))
         0: return coord_type'($urandom);
         1: return lo;
         2: return hi;
         3: return coord_type'(a + $urandom_range(0, 3) - 1);
         default: return coord_type'(a - span + longint'({$urandom, $urandom}
                                     % longint'(3 * span)));
      endcase
   endfunction

   function automatic segment_type rand_segment();
      segment_type s;
      s.sx = pick(sb.x_min, sb.x_max);
      s.sy = pick(sb.y_min, sb.y_max);
      s.ex = pick(sb.x_min, sb.x_max);
      s.ey = pick(sb.y_min, sb.y_max);
      return s;
   endfunction

   localparam coord_type ONE = 32'sd65536;
   localparam coord_type HALF = 32'sd32768;
   localparam coord_type CMIN = 32'sh8000_0000;
   localparam coord_type CMAX = 32'sh7fff_ffff;

   initial begin
      segment_type dir[$];
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // unit square from reset
      dir = '{
         '{HALF, HALF, HALF + 1, HALF - 1},
         '{0, 0, ONE, ONE},
         '{-ONE, HALF, HALF, HALF},
         '{HALF, HALF, HALF, 2 * ONE},
         '{2 * ONE, HALF, HALF, HALF + 3},
         '{HALF, -ONE, HALF, HALF},
         '{-ONE, -ONE, 2 * ONE, 2 * ONE},
         '{-ONE, HALF, 2 * ONE, HALF},
         '{-ONE, -ONE, -ONE, 2 * ONE},
         '{2 * ONE, -ONE, 3 * ONE, 2 * ONE},
         '{0, HALF, -ONE, HALF},
         '{0, HALF, HALF, HALF},
         '{ONE, 0, 2 * ONE, ONE},
         '{-ONE, -2 * ONE, 2 * ONE, 4 * ONE + 1},
         '{HALF, HALF, -ONE, HALF + 3},
         '{CMIN, CMIN, CMAX, CMAX},
         '{CMAX, CMIN, CMIN, CMAX},
         '{CMIN, HALF, CMAX, HALF + 1},
         '{HALF, CMAX, HALF, CMIN},
         '{CMAX, CMAX, CMAX, CMAX}
      };
      foreach (dir[i]) send_segment(dir[i]);

      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: set_rect(-ONE, -ONE, ONE, ONE);
            1: set_rect(CMIN, CMIN, CMAX, CMAX);
            2: set_rect(ONE, ONE, ONE, ONE);
            3: set_rect(3 * ONE, 2 * ONE, -ONE, -ONE);
            4: set_rect(CMAX - ONE, CMIN, CMAX, CMIN + 5);
            5: begin
               set_rect(-100, -7, 200, 9);
               write_csr(3'd5, coord_type'($urandom));
               write_csr(3'd7, coord_type'($urandom));
            end
            default: set_rect(coord_type'($urandom_range(0, 1 << 24)) - (1 << 23),
                              coord_type'($urandom_range(0, 1 << 24)) - (1 << 23),
                              coord_type'($urandom_range(1 << 23, 1 << 26)),
                              coord_type'($urandom_range(1 << 23, 1 << 26)));
         endcase
         if (ph == 7) quiet = 1;
         if (ph == 2) begin
            hold_request = 1;
            repeat (20) send_segment(rand_segment());
         end
         if (ph == 4) begin
            repeat (10) send_segment(rand_segment());
            wait (sb.expected_q.size() == 0);
            @(negedge clock);
         end
         repeat (160) send_segment(rand_segment());
      end

      drain();
      repeat (200) @(posedge clock);
      $display("summary: %0d segments sent, %0d results checked, %0d deleted",
               sent, sb.checked, sb.deleted);
      $display("rectangles: unit, centered, full range, degenerate, inverted, edge, random");
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         if (sb.expected_q.size() != 0)
            $display("%0d results never arrived", sb.expected_q.size());
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
